// ===== sv/dedup_task_dispatch_queue_top_assert.svh =====
// Assertion macros for the task dispatch queue checker.
`ifndef DEDUP_TASK_DISPATCH_QUEUE_TOP_ASSERT_SVH
`define DEDUP_TASK_DISPATCH_QUEUE_TOP_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define DTDQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dtdq same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted.
`define DTDQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dtdq next-cycle check failed");

// Next-cycle implication that also covers the reset cycles.
`define DTDQ_ASSERT_RST(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("dtdq reset check failed");

`endif

// ===== sv/dtdq_pkg.sv =====
`default_nettype none
package dtdq_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int ID_BITS_DEF     = 8;
    localparam int TASK_ID_W       = 8;
    localparam int STATUS_W        = 2;

    localparam logic ACT_DISPATCH = 1'b0;
    localparam logic ACT_ADD      = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ADD_STORED = 2'd0,
        ADD_DUP    = 2'd1,
        ADD_FULL   = 2'd2,
        ADD_IDLE   = 2'd3
    } t_add_status;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic exec;
    } t_dp_cmd;

endpackage
`default_nettype wire

// ===== sv/dtdq_ctrl.sv =====
`default_nettype none
module dtdq_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output dtdq_pkg::t_dp_cmd o_cmd
);
    import dtdq_pkg::*;

    typedef enum logic [1:0] {
        S_EMPTY = 2'b01,
        S_HOLD  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    // Stall only when the result register is full and not drained this cycle.
    assign o_in_stall  = (r_state == S_HOLD) && i_out_stall;
    assign o_out_valid = (r_state == S_HOLD);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_cmd.exec  = w_accept;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_EMPTY: begin
                if (w_accept) n_state = S_HOLD;
            end
            S_HOLD: begin
                if (!i_out_stall && !w_accept) n_state = S_EMPTY;
            end
            default: n_state = S_EMPTY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== sv/dtdq_datapath.sv =====
`default_nettype none
module dtdq_datapath #(
    parameter int QUEUE_DEPTH = dtdq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = dtdq_pkg::ID_BITS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  dtdq_pkg::t_dp_cmd                 i_cmd,
    input  wire                               i_action,
    input  wire  [dtdq_pkg::TASK_ID_W-1:0]    i_task_id,
    output logic [dtdq_pkg::TASK_ID_W-1:0]    o_issued_task,
    output logic [dtdq_pkg::STATUS_W-1:0]     o_add_status
);
    import dtdq_pkg::*;

    logic [ID_BITS-1:0]           r_slots [QUEUE_DEPTH];
    logic [ID_BITS-1:0]           n_slots [QUEUE_DEPTH];
    logic [TASK_ID_W-1:0]         r_issued;
    logic [TASK_ID_W-1:0]         n_issued;
    t_add_status                  r_status;
    t_add_status                  n_status;

    logic [ID_BITS+TASK_ID_W-1:0] w_id_ext;
    logic [ID_BITS+TASK_ID_W-1:0] w_head_ext;
    logic [ID_BITS-1:0]           w_id;
    logic [TASK_ID_W-1:0]         w_head;
    logic [QUEUE_DEPTH-1:0]       w_match;
    logic [QUEUE_DEPTH-1:0]       w_empty;
    logic [QUEUE_DEPTH-1:0]       w_hit;
    logic [QUEUE_DEPTH-1:0]       w_first;

    // Fit the identifier to ID_BITS, and the head back to the port width.
    assign w_id_ext   = {{ID_BITS{1'b0}}, i_task_id};
    assign w_id       = w_id_ext[ID_BITS-1:0];
    assign w_head_ext = {{TASK_ID_W{1'b0}}, r_slots[0]};
    assign w_head     = w_head_ext[TASK_ID_W-1:0];

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            w_match[i] = (r_slots[i] == w_id);
            w_empty[i] = (r_slots[i] == '0);
        end
    end

    // Lowest slot that matches or is empty wins the scan.
    assign w_hit   = w_match | w_empty;
    assign w_first = w_hit & (~w_hit + QUEUE_DEPTH'(1));

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_slots[i] = r_slots[i];
        end
        n_issued = '0;
        n_status = ADD_STORED;
        if (i_action == ACT_DISPATCH) begin
            n_issued = w_head;
            if (r_slots[0] != '0) begin
                for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                    n_slots[i] = r_slots[i+1];
                end
                n_slots[QUEUE_DEPTH-1] = '0;
            end
        end else if (w_id == '0) begin
            n_status = ADD_IDLE;
        end else if (|(w_first & w_match)) begin
            n_status = ADD_DUP;
        end else if (|(w_first & w_empty)) begin
            n_status = ADD_STORED;
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (w_first[i]) n_slots[i] = w_id;
            end
        end else begin
            n_status = ADD_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_slots[i] <= '0;
            end
        end else if (i_cmd.exec) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_slots[i] <= n_slots[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_issued <= n_issued;
            r_status <= n_status;
        end
    end

    assign o_issued_task = r_issued;
    assign o_add_status  = r_status;

endmodule
`default_nettype wire

// ===== sv/dedup_task_dispatch_queue_top.sv =====
// Deduplicating task dispatch queue.
// Input channel: i_in_valid / o_in_stall carry i_action and i_task_id. A
// transfer happens on a rising edge with valid high and stall low. Action 0
// dispatches the head task; action 1 adds i_task_id unless it is already
// queued or the queue is full. Identifier 0 marks an empty slot.
// Output channel: o_out_valid / i_out_stall carry o_issued_task and
// o_add_status (0 stored, 1 duplicate, 2 full, 3 idle id ignored).
// The result sits in the output register in the cycle after the input
// transfer. Throughput: one item per cycle unless the receiver stalls;
// the slot compares, the first-hit priority pick and the head shift are
// all combinational between slot register updates.
// Stall: while the receiver stalls, the result holds and o_in_stall rises
// only if a result is waiting; a new item is taken in the same cycle that
// the waiting result is drained.
// Reset (synchronous, active low): all slots clear to empty and the output
// register is marked empty.
`default_nettype none
module dedup_task_dispatch_queue_top #(
    parameter int QUEUE_DEPTH = dtdq_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = dtdq_pkg::ID_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_stall,
    input  wire                            i_action,
    input  wire  [dtdq_pkg::TASK_ID_W-1:0] i_task_id,
    output logic                           o_out_valid,
    input  wire                            i_out_stall,
    output logic [dtdq_pkg::TASK_ID_W-1:0] o_issued_task,
    output logic [dtdq_pkg::STATUS_W-1:0]  o_add_status
);
    import dtdq_pkg::*;

    t_dp_cmd w_cmd;

    // Controller: owns the handshake and the output-full flag.
    dtdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    // Datapath: slot registers, scan, shift and result register.
    dtdq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_action      (i_action),
        .i_task_id     (i_task_id),
        .o_issued_task (o_issued_task),
        .o_add_status  (o_add_status)
    );

endmodule
`default_nettype wire

// ===== sv/dtdq_checker.sv =====
`default_nettype none
`include "dedup_task_dispatch_queue_top_assert.svh"
module dtdq_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_in_valid,
    input wire       o_in_stall,
    input wire       o_out_valid,
    input wire       i_out_stall,
    input wire [dtdq_pkg::TASK_ID_W-1:0] o_issued_task,
    input wire [dtdq_pkg::STATUS_W-1:0]  o_add_status
);
    import dtdq_pkg::*;

    // A stalled result holds.
    `DTDQ_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_issued_task) && $stable(o_add_status))

    // An input transfer always leaves a result waiting.
    `DTDQ_ASSERT_NEXT(a_accept_fills, i_in_valid && !o_in_stall, o_out_valid)

    // Input stalls only behind a waiting, stalled result.
    `DTDQ_ASSERT_NOW(a_stall_cause, o_in_stall, o_out_valid && i_out_stall)

    // A result carries either an issued task or an add status, never both.
    `DTDQ_ASSERT_NOW(a_result_form, o_out_valid, o_issued_task == '0 || o_add_status == ADD_STORED)

    // Reset empties the output register.
    `DTDQ_ASSERT_RST(a_reset_empty, !i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind dedup_task_dispatch_queue_top dtdq_checker u_checker (.*);
`default_nettype wire
